// File: hdl/bfbm_pkg.sv
// Shared types, constants and the per-byte run function of the block free bitmap manager.
package bfbm_pkg;

  localparam int RNG_W       = 17;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int RUN_SAT     = 4095;
  localparam int START_SAT   = 2047;

  typedef enum logic [1:0] {
    CMD_MARK    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_SCAN,
    S_FLUSH,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } acc_ctl_t;

  typedef struct packed {
    logic [3:0] lead;
    logic [3:0] trail;
    logic [3:0] nfree;
    logic [3:0] imax;
    logic [2:0] ioff;
  } byte_info_t;

  // Free runs of one byte, block order from the most significant bit down.
  function automatic byte_info_t byte_info(input logic [7:0] b);
    byte_info_t r;
    logic [3:0] run;
    logic       used_seen;
    r         = '0;
    run       = '0;
    used_seen = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!b[7-j]) begin
        run     = run + 4'd1;
        r.nfree = r.nfree + 4'd1;
        if (!used_seen) begin
          r.lead = r.lead + 4'd1;
        end
      end else begin
        if (used_seen && (run > r.imax)) begin
          r.imax = run;
          r.ioff = 3'(j - int'(run));
        end
        used_seen = 1'b1;
        run       = '0;
      end
    end
    r.trail = run;
    return r;
  endfunction

endpackage

// File: hdl/bfbm_run_acc.sv
// Byte-wide free run accumulator used by the bitmap query scan.
module bfbm_run_acc #(
  parameter int BW = 11,
  parameter int CW = 12
) (
  input  logic               clk,
  input  bfbm_pkg::acc_ctl_t ctl,
  input  logic [7:0]         byte_data,
  input  logic [BW-1:0]      byte_base,
  output logic [CW-1:0]      fin_free,
  output logic [CW-1:0]      fin_len,
  output logic [BW-1:0]      fin_start
);

  logic [CW-1:0] free_r;
  logic [CW-1:0] cur_len_r;
  logic [BW-1:0] cur_start_r;
  logic [CW-1:0] best_len_r;
  logic [BW-1:0] best_start_r;

  bfbm_pkg::byte_info_t info;
  logic [BW-1:0] run_start;
  logic [CW-1:0] c1_len;
  logic [CW-1:0] b1_len;
  logic [BW-1:0] b1_start;
  logic [CW-1:0] best_len_nxt;
  logic [BW-1:0] best_start_nxt;
  logic [BW-1:0] int_start;

  always_comb begin
    info      = bfbm_pkg::byte_info(byte_data);
    run_start = (cur_len_r == '0) ? byte_base : cur_start_r;
    c1_len    = cur_len_r + CW'(info.lead);
    int_start = byte_base + BW'(info.ioff);
    if (c1_len > best_len_r) begin
      b1_len   = c1_len;
      b1_start = run_start;
    end else begin
      b1_len   = best_len_r;
      b1_start = best_start_r;
    end
    if (CW'(info.imax) > b1_len) begin
      best_len_nxt   = CW'(info.imax);
      best_start_nxt = int_start;
    end else begin
      best_len_nxt   = b1_len;
      best_start_nxt = b1_start;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      free_r       <= '0;
      cur_len_r    <= '0;
      cur_start_r  <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
    end else if (ctl.step) begin
      free_r <= free_r + CW'(info.nfree);
      if (byte_data == 8'h00) begin
        cur_len_r   <= c1_len;
        cur_start_r <= run_start;
      end else begin
        best_len_r   <= best_len_nxt;
        best_start_r <= best_start_nxt;
        cur_len_r    <= CW'(info.trail);
        cur_start_r  <= byte_base + BW'(4'd8 - info.trail);
      end
    end
  end

  always_comb begin
    fin_free = free_r;
    if (cur_len_r > best_len_r) begin
      fin_len   = cur_len_r;
      fin_start = cur_start_r;
    end else begin
      fin_len   = best_len_r;
      fin_start = best_start_r;
    end
  end

endmodule

// File: hdl/block_free_bitmap_manager.sv
// Top level of the block free bitmap manager: bitmap memory, sequencer and result register.
//
//   channel | bus                    | contents
//   in      | in_tuser, in_tdata     | command; first_block, block_count
//   out     | out_tuser, out_tdata   | range_error; free_count, largest_run, largest_start
//
// After reset the bitmap is cleared one byte a cycle with in_tready low.
// A query scans every bitmap byte through the single-byte memory read port.
// Mark and release read and then write each byte touched; rejected requests go straight to the result.
// One request is handled at a time; a result waits in the output register until taken.
module block_free_bitmap_manager #(
  parameter int BITMAP_BYTES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bfbm_pkg::IN_TDATA_W-1:0]      in_tdata,   // first_block, block_count
  input  logic [1:0]                           in_tuser,   // command
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bfbm_pkg::OUT_TDATA_W-1:0]     out_tdata,  // free_count, largest_run, largest_start
  output logic                                 out_tuser   // range_error
);

  localparam int TOTAL_BLOCKS = BITMAP_BYTES * 8;
  localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int BW = AW + 3;
  localparam int CW = $clog2(TOTAL_BLOCKS + 1);
  localparam int RW = bfbm_pkg::RNG_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_BYTES - 1);
  localparam logic [RW-1:0] TOTAL_L   = RW'(TOTAL_BLOCKS);

  bfbm_pkg::state_t   state_r, state_nxt;
  bfbm_pkg::acc_ctl_t acc_ctl;

  logic [AW-1:0] addr_r, addr_nxt;
  logic [1:0]    cmd_r;
  logic [RW-1:0] lo_r;
  logic [RW-1:0] hi_r;
  logic [AW-1:0] base_r;
  logic          scan_vld_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem_r [BITMAP_BYTES];
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [7:0]    rmw_mask;

  logic [11:0] res_free_r;
  logic [11:0] res_len_r;
  logic [10:0] res_start_r;
  logic        res_err_r;
  logic        out_vld_r;
  logic [34:0] out_data_r;
  logic        out_err_r;

  logic [10:0]   in_first;
  logic [15:0]   in_count;
  logic [RW-1:0] in_end;
  logic          in_acc;
  logic          in_rng;
  logic          in_bad;
  logic          last_rmw;
  logic          out_free;

  logic [CW-1:0] fin_free;
  logic [CW-1:0] fin_len;
  logic [BW-1:0] fin_start;

  assign in_first = in_tdata[10:0];
  assign in_count = in_tdata[26:11];
  assign in_end   = RW'(in_first) + RW'(in_count);
  assign in_acc   = in_tvalid && in_tready;
  assign in_rng   = (in_tuser == bfbm_pkg::CMD_MARK) || (in_tuser == bfbm_pkg::CMD_RELEASE);
  assign in_bad   = in_end > TOTAL_L;
  assign last_rmw = RW'(addr_r) == (hi_r >> 3);
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    rmw_mask = '0;
    for (int j = 0; j < 8; j++) begin
      rmw_mask[7-j] = (RW'({addr_r, 3'(j)}) >= lo_r) && (RW'({addr_r, 3'(j)}) <= hi_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfbm_pkg::S_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = bfbm_pkg::S_IDLE;
        end
      end
      bfbm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_rng && (in_count != '0) && !in_bad) begin
            state_nxt = bfbm_pkg::S_RMW_RD;
          end else if (in_tuser == bfbm_pkg::CMD_QUERY) begin
            state_nxt = bfbm_pkg::S_SCAN;
          end else begin
            state_nxt = bfbm_pkg::S_DONE;
          end
        end
      end
      bfbm_pkg::S_RMW_RD: state_nxt = bfbm_pkg::S_RMW_WR;
      bfbm_pkg::S_RMW_WR: begin
        state_nxt = last_rmw ? bfbm_pkg::S_DONE : bfbm_pkg::S_RMW_RD;
      end
      bfbm_pkg::S_SCAN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = bfbm_pkg::S_FLUSH;
        end
      end
      bfbm_pkg::S_FLUSH: state_nxt = bfbm_pkg::S_FIN;
      bfbm_pkg::S_FIN:   state_nxt = bfbm_pkg::S_DONE;
      bfbm_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = bfbm_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfbm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    addr_nxt      = addr_r;
    acc_ctl.start = 1'b0;
    acc_ctl.step  = scan_vld_r;
    unique case (state_r)
      bfbm_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = (addr_r == LAST_ADDR) ? '0 : addr_r + 1'b1;
      end
      bfbm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          addr_nxt      = in_rng ? AW'(in_first >> 3) : '0;
          acc_ctl.start = in_tuser == bfbm_pkg::CMD_QUERY;
        end
      end
      bfbm_pkg::S_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (cmd_r == bfbm_pkg::CMD_MARK) ? (rd_data_r | rmw_mask)
                                                  : (rd_data_r & ~rmw_mask);
        if (!last_rmw) begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      bfbm_pkg::S_SCAN: begin
        addr_nxt = (addr_r == LAST_ADDR) ? '0 : addr_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[addr_r] <= mem_wdata;
    end
    rd_data_r <= mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bfbm_pkg::S_CLEAR;
      addr_r     <= '0;
      scan_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      scan_vld_r <= state_r == bfbm_pkg::S_SCAN;
      if (state_r == bfbm_pkg::S_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= addr_r;
    if (in_acc) begin
      cmd_r       <= in_tuser;
      lo_r        <= RW'(in_first);
      hi_r        <= in_end - RW'(1);
      res_free_r  <= '0;
      res_len_r   <= '0;
      res_start_r <= '0;
      res_err_r   <= in_rng && (in_count != '0) && in_bad;
    end
    if (state_r == bfbm_pkg::S_FIN) begin
      res_free_r  <= (32'(fin_free) > bfbm_pkg::RUN_SAT) ? 12'(bfbm_pkg::RUN_SAT)
                                                        : 12'(fin_free);
      res_len_r   <= (32'(fin_len) > bfbm_pkg::RUN_SAT) ? 12'(bfbm_pkg::RUN_SAT)
                                                       : 12'(fin_len);
      res_start_r <= (32'(fin_start) > bfbm_pkg::START_SAT) ? 11'(bfbm_pkg::START_SAT)
                                                           : 11'(fin_start);
    end
    if (state_r == bfbm_pkg::S_DONE && out_free) begin
      out_data_r <= {res_start_r, res_len_r, res_free_r};
      out_err_r  <= res_err_r;
    end
  end

  bfbm_run_acc #(
    .BW(BW),
    .CW(CW)
  ) u_run_acc (
    .clk       (clk),
    .ctl       (acc_ctl),
    .byte_data (rd_data_r),
    .byte_base ({base_r, 3'b000}),
    .fin_free  (fin_free),
    .fin_len   (fin_len),
    .fin_start (fin_start)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b00000, out_data_r};
  assign out_tuser  = out_err_r;

  a_run_within_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfbm_pkg::S_FIN) |-> (fin_len <= fin_free))
    else $error("Longest free run exceeds the free total.");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == bfbm_pkg::S_DONE))
    else $error("Result raised outside the completion state.");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[34:0] == '0))
    else $error("Rejected range request carries summary data.");

  a_request_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != bfbm_pkg::S_IDLE))
    else $error("Accepted request left the sequencer idle.");

endmodule
